FILE: rtl/scpa_pkg.sv
// Shared types, codes and constants for the size-class pool allocator.
package scpa_pkg;

	localparam int ADDR_W  = 20;
	localparam int SIZE_W  = 32;
	localparam int PAGES_W = 9;
	localparam int STS_W   = 3;
	localparam int CLS_W   = 2;
	localparam int NUM_CLS = 3;

	localparam int SMALL_SHIFT  = 7;
	localparam int SMALL_BYTES  = 128;
	localparam int MEDIUM_BYTES = 256;
	localparam int LARGE_BYTES  = 512;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
	localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;
	localparam logic [CLS_W-1:0] CLS_EXT    = 2'd3;

	typedef enum logic [STS_W-1:0] {
		STS_OK   = 3'd0,
		STS_EXT  = 3'd1,
		STS_OOM  = 3'd2,
		STS_NULL = 3'd3,
		STS_OVF  = 3'd4
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic pop_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mem_pop;
	} stat_t;

	function automatic logic [CLS_W-1:0] classify(input logic [SIZE_W-1:0] size);
		logic [CLS_W-1:0] c;
		if (size <= SIZE_W'(SMALL_BYTES)) c = CLS_SMALL;
		else if (size <= SIZE_W'(MEDIUM_BYTES)) c = CLS_MEDIUM;
		else if (size <= SIZE_W'(LARGE_BYTES)) c = CLS_LARGE;
		else c = CLS_EXT;
		return c;
	endfunction

endpackage

FILE: rtl/scpa_if.sv
// Request and response channel interfaces of the allocator.
interface scpa_req_if import scpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] slot_address;
	logic              no_address;

	modport source (output valid, mode, request_size, slot_address, no_address, input ready);
	modport sink (input valid, mode, request_size, slot_address, no_address, output ready);
endinterface

interface scpa_rsp_if import scpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] granted_address;
	logic [STS_W-1:0]  status;
	logic [CLS_W-1:0]  size_class;

	modport source (output valid, granted_address, status, size_class, input ready);
	modport sink (input valid, granted_address, status, size_class, output ready);
endinterface

FILE: rtl/scpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

FILE: rtl/scpa_ctrl.sv
// Handshake controller: accepts requests, sequences RAM pops, owns response valid.
module scpa_ctrl import scpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   load;

	// take a request only when the response register is free or draining
	assign in_ready     = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign cmd.accept   = in_valid && in_ready;
	assign cmd.pop_load = (state_q == ST_POP);
	assign load         = (cmd.accept && !stat.mem_pop) || cmd.pop_load;
	assign out_valid    = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && stat.mem_pop) state_d = ST_POP;
			end
			ST_POP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/scpa_dp.sv
// Datapath: page counter, per-class stack lanes with carve pointers, response register.
module scpa_dp import scpa_pkg::*; #(
	parameter int MAX_PAGES  = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [PAGES_W-1:0] cfg_data,
	input  logic               req_mode,
	input  logic [SIZE_W-1:0]  req_size,
	input  logic [ADDR_W-1:0]  req_addr,
	input  logic               req_null,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic [ADDR_W-1:0]  rsp_addr,
	output logic [STS_W-1:0]   rsp_status,
	output logic [CLS_W-1:0]   rsp_class
);
	logic [PAGES_W-1:0] pool_pages_q;
	logic [PAGES_W-1:0] page_top_q;
	logic [PAGES_W-1:0] page_idx;
	logic [PAGES_W-1:0] cfg_sat;
	logic               page_avail;
	logic [CLS_W-1:0]   req_cls;
	logic [CLS_W-1:0]   cls_q;

	logic [ADDR_W-1:0] lane_gnt  [NUM_CLS];
	status_t           lane_sts  [NUM_CLS];
	logic [ADDR_W-1:0] lane_rd   [NUM_CLS];
	logic              lane_pop  [NUM_CLS];
	logic              lane_take [NUM_CLS];

	assign req_cls    = classify(req_size);
	assign page_avail = (page_top_q != '0);
	// pages leave the pool in order 0, 1, 2, ...
	assign page_idx   = pool_pages_q - page_top_q;
	assign cfg_sat    = (32'(cfg_data) > 32'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES) : cfg_data;
	assign stat.mem_pop = lane_pop[0] || lane_pop[1] || lane_pop[2];

	for (genvar g = 0; g < NUM_CLS; g++) begin : g_cls
		localparam int SHIFT    = SMALL_SHIFT + g;
		localparam int BYTES    = 1 << SHIFT;
		localparam int PER_PAGE = PAGE_BYTES / BYTES;
		localparam int DEPTH    = MAX_PAGES * PER_PAGE;
		localparam int IW       = ADDR_W - SHIFT;
		localparam int CW       = $clog2(DEPTH + 1);
		localparam int AW       = $clog2(DEPTH);
		localparam int NW       = $clog2(PER_PAGE);

		logic [CW-1:0] mem_cnt_q;
		logic [CW-1:0] cnt_dec;
		logic [NW-1:0] carve_n_q;
		logic [IW-1:0] carve_next_q;
		logic [IW-1:0] page_base;
		logic [IW-1:0] rdata;
		logic [CW:0]   top;
		logic          sel, mem_has, carve_has, full;
		logic          pop, carve, take, push;
		logic [ADDR_W-1:0] gnt;
		status_t       sts;

		assign sel       = cmd.accept && (req_cls == CLS_W'(g));
		assign mem_has   = (mem_cnt_q != '0);
		assign carve_has = (carve_n_q != '0);
		assign top       = (CW+1)'(mem_cnt_q) + (CW+1)'(carve_n_q);
		assign full      = (top >= (CW+1)'(DEPTH));
		assign cnt_dec   = mem_cnt_q - CW'(1);
		assign page_base = IW'(32'(page_idx) * 32'(PER_PAGE));

		always_comb begin
			pop   = 1'b0;
			carve = 1'b0;
			take  = 1'b0;
			push  = 1'b0;
			gnt   = '0;
			sts   = STS_OK;
			if (req_mode == MODE_ALLOC) begin
				if (mem_has) begin
					pop = 1'b1;
				end else if (carve_has) begin
					carve = 1'b1;
					gnt   = {carve_next_q, {SHIFT{1'b0}}};
				end else if (page_avail) begin
					take = 1'b1;
					gnt  = {page_base, {SHIFT{1'b0}}};
				end else begin
					sts = STS_OOM;
				end
			end else begin
				if (req_null) sts = STS_NULL;
				else if (full) sts = STS_OVF;
				else push = 1'b1;
			end
		end

		assign lane_gnt[g]  = gnt;
		assign lane_sts[g]  = sts;
		assign lane_pop[g]  = sel && pop;
		assign lane_take[g] = sel && take;
		assign lane_rd[g]   = {rdata, {SHIFT{1'b0}}};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mem_cnt_q <= '0;
				carve_n_q <= '0;
			end else if (cfg_we) begin
				mem_cnt_q <= '0;
				carve_n_q <= '0;
			end else if (sel) begin
				if (pop) mem_cnt_q <= cnt_dec;
				if (push) mem_cnt_q <= mem_cnt_q + CW'(1);
				if (carve) carve_n_q <= carve_n_q - NW'(1);
				if (take) carve_n_q <= NW'(PER_PAGE - 1);
			end
		end

		always_ff @(posedge clk) begin
			if (sel && carve) carve_next_q <= carve_next_q + IW'(1);
			if (sel && take) carve_next_q <= page_base + IW'(1);
		end

		scpa_ram #(
			.WIDTH(IW),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (sel && push),
			.waddr(mem_cnt_q[AW-1:0]),
			.wdata(req_addr[ADDR_W-1:SHIFT]),
			.re   (sel && pop),
			.raddr(cnt_dec[AW-1:0]),
			.rdata(rdata)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_pages_q <= '0;
			page_top_q   <= '0;
		end else if (cfg_we) begin
			pool_pages_q <= cfg_sat;
			page_top_q   <= cfg_sat;
		end else if (lane_take[0] || lane_take[1] || lane_take[2]) begin
			page_top_q <= page_top_q - PAGES_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cls_q     <= req_cls;
			rsp_class <= req_cls;
			if (!stat.mem_pop) begin
				case (req_cls)
					CLS_SMALL: begin
						rsp_addr   <= lane_gnt[0];
						rsp_status <= lane_sts[0];
					end
					CLS_MEDIUM: begin
						rsp_addr   <= lane_gnt[1];
						rsp_status <= lane_sts[1];
					end
					CLS_LARGE: begin
						rsp_addr   <= lane_gnt[2];
						rsp_status <= lane_sts[2];
					end
					default: begin
						rsp_addr   <= '0;
						rsp_status <= STS_EXT;
					end
				endcase
			end
		end else if (cmd.pop_load) begin
			rsp_status <= STS_OK;
			case (cls_q)
				CLS_SMALL: rsp_addr <= lane_rd[0];
				CLS_MEDIUM: rsp_addr <= lane_rd[1];
				CLS_LARGE: rsp_addr <= lane_rd[2];
				default: rsp_addr <= '0;
			endcase
		end
	end
endmodule

FILE: rtl/size_class_pool_allocator_unit.sv
// Top level of the size-class pool allocator: controller, datapath and channel ports.
//
// Hands out 128, 256 and 512 byte slots from a pool of PAGE_BYTES pages and takes them back.
// Each request beat gives one response beat. For most requests, class selection, stack
// decision and counter updates all happen at the accepting edge and the result lands in
// the response register. An allocation that pops a previously freed slot waits for the
// registered read of that class's stack RAM and loads it in the POP state. A response
// waiting in the output register does not block the next request if it is taken in the
// same cycle. Pages are never returned, so the page stack is just a counter: pages go out
// in order 0, 1, 2, ... A page refill does not write its slots into the stack; it loads a
// carve pointer and count that sit below the freed slots in the class stack. Writing cfg_data
// with cfg_we sets the page count (saturated to MAX_PAGES) and empties every class stack;
// there is no clearing pass, and the write must happen only while the block is idle. Each
// class owns one RAM of MAX_PAGES*(PAGE_BYTES/size) entries holding freed slot indices.
module size_class_pool_allocator_unit import scpa_pkg::*; #(
	parameter int MAX_PAGES  = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [PAGES_W-1:0] cfg_data,
	scpa_req_if.sink           req,
	scpa_rsp_if.source         rsp
);
	cmd_t  cmd;
	stat_t stat;

	// handshake and sequencing
	scpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stacks, counters and the response register
	scpa_dp #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_mode  (req.mode),
		.req_size  (req.request_size),
		.req_addr  (req.slot_address),
		.req_null  (req.no_address),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_addr  (rsp.granted_address),
		.rsp_status(rsp.status),
		.rsp_class (rsp.size_class)
	);
endmodule

FILE: test/scpa_grant_checker.sv
// Watches the allocator channels, predicts each response beat and compares it field by field.
module scpa_grant_checker import scpa_pkg::*; #(
	parameter int MAX_PAGES  = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [PAGES_W-1:0] cfg_data,
	scpa_req_if                req,
	scpa_rsp_if                rsp,
	output int unsigned        mismatches,
	output int unsigned        outstanding,
	output int unsigned        beats_checked,
	output logic [4:0]         status_seen
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           sts;
		logic [CLS_W-1:0]  cls;
	} grant_t;

	int unsigned page_count;
	int unsigned pages_left;
	int unsigned free_slots[NUM_CLS][$];
	grant_t      pending_grants[$];

	function automatic void rebuild_pool(input logic [PAGES_W-1:0] pages);
		int unsigned k;
		page_count = (pages > MAX_PAGES) ? MAX_PAGES : pages;
		pages_left = page_count;
		for (k = 0; k < NUM_CLS; k++)
			free_slots[k].delete();
	endfunction

	function automatic grant_t predict_grant(input logic mode, input logic [SIZE_W-1:0] size,
			input logic [ADDR_W-1:0] slot, input logic null_ptr);
		grant_t      g;
		int unsigned c, bytes, per_page, base, k;
		if (size <= SIZE_W'(SMALL_BYTES))
			c = CLS_SMALL;
		else if (size <= SIZE_W'(MEDIUM_BYTES))
			c = CLS_MEDIUM;
		else if (size <= SIZE_W'(LARGE_BYTES))
			c = CLS_LARGE;
		else
			c = CLS_EXT;
		g.cls  = CLS_W'(c);
		g.addr = '0;
		g.sts  = STS_OK;
		if (c == CLS_EXT) begin
			g.sts = STS_EXT;
			return g;
		end
		bytes = SMALL_BYTES << c;
		if (mode == MODE_ALLOC) begin
			if (free_slots[c].size() > 0) begin
				g.addr = ADDR_W'(free_slots[c].pop_back() * bytes);
			end else if (pages_left == 0) begin
				g.sts = STS_OOM;
			end else begin
				// carve the next page: hand out its base, stack the rest so base+1 pops next
				per_page = PAGE_BYTES / bytes;
				base = (page_count - pages_left) * per_page;
				pages_left--;
				for (k = per_page - 1; k >= 1; k--)
					free_slots[c].push_back(base + k);
				g.addr = ADDR_W'(base * bytes);
			end
		end else if (null_ptr) begin
			g.sts = STS_NULL;
		end else if (free_slots[c].size() >= MAX_PAGES * PAGE_BYTES / bytes) begin
			g.sts = STS_OVF;
		end else begin
			free_slots[c].push_back(slot / bytes);
		end
		return g;
	endfunction

	task automatic report_mismatch(input string what, input grant_t want, input grant_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t grant mismatch (%s): expected addr=%h sts=%0d cls=%0d, got addr=%h sts=%0d cls=%0d",
				$realtime, what, want.addr, want.sts, want.cls, got.addr, got.sts, got.cls);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		grant_t got;
		if (!arst_n) begin
			rebuild_pool('0);
			pending_grants.delete();
			mismatches    = 0;
			outstanding   = 0;
			beats_checked = 0;
			status_seen   = '0;
		end else begin
			if (cfg_we)
				rebuild_pool(cfg_data);
			if (req.valid && req.ready)
				pending_grants.push_back(predict_grant(req.mode, req.request_size,
					req.slot_address, req.no_address));
			if (rsp.valid && rsp.ready) begin
				beats_checked++;
				got.addr = rsp.granted_address;
				got.sts  = status_t'(rsp.status);
				got.cls  = rsp.size_class;
				if (pending_grants.size() == 0) begin
					report_mismatch("beat with nothing pending", '0, got);
				end else begin
					want = pending_grants.pop_front();
					if ((got.addr !== want.addr) || (got.sts !== want.sts) || (got.cls !== want.cls))
						report_mismatch("field differs", want, got);
					else
						status_seen[want.sts] = 1'b1;
				end
			end
			outstanding = pending_grants.size();
		end
	end

endmodule

FILE: test/tb_top.sv
// Top of the allocator testbench: clock, reset, stimulus, the block and its checker.
module tb_top;
	import scpa_pkg::*;

	localparam int MAX_PAGES    = 256;
	localparam int PAGE_BYTES   = 4096;
	localparam int FILL_FREES   = 40;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 200;
	localparam int LIMIT_CYCLES = 1_500_000;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [ADDR_W-1:0] addr;
	} slot_ref_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               cfg_we   = 1'b0;
	logic [PAGES_W-1:0] cfg_data = '0;

	scpa_req_if req();
	scpa_rsp_if rsp();

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned beats_checked;
	logic [4:0]  status_seen;

	// live allocations, harvested from grant beats, feed well-formed frees
	slot_ref_t   live_slots[$];
	logic        sent_modes[$];
	bit          hold_request = 1'b0;
	int unsigned beats_sent   = 0;
	int unsigned calm_items   = 0;

	size_class_pool_allocator_unit #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	scpa_grant_checker #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.req           (req),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.beats_checked (beats_checked),
		.status_seen   (status_seen)
	);

	always #5 clk = ~clk;

	// hold reset from the start, release it on a falling edge, never assert it again
	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
	end

	// bound the run; a hang ends here
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("watchdog expired with %0d beats still pending", outstanding);
		$display("== FAIL ==");
		$finish;
	end

	// most gaps short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	function automatic logic [SIZE_W-1:0] size_in_class(input int unsigned c);
		case (c)
			CLS_SMALL:  return $urandom_range(0, SMALL_BYTES);
			CLS_MEDIUM: return $urandom_range(SMALL_BYTES + 1, MEDIUM_BYTES);
			CLS_LARGE:  return $urandom_range(MEDIUM_BYTES + 1, LARGE_BYTES);
			default:    return $urandom_range(LARGE_BYTES + 1, 32'hFFFF_FFFF);
		endcase
	endfunction

	// track request modes in order so grant beats can be told from free beats
	always @(posedge clk) begin
		slot_ref_t s;
		logic      m;
		if (arst_n) begin
			if (req.valid && req.ready)
				sent_modes.push_back(req.mode);
			if (rsp.valid && rsp.ready && sent_modes.size() > 0) begin
				m = sent_modes.pop_front();
				if (m == MODE_ALLOC && rsp.status == STS_OK) begin
					s.cls  = rsp.size_class;
					s.addr = rsp.granted_address;
					live_slots.push_back(s);
				end
			end
		end
	end

	// response side: random stalls, calm stretches, and one long hold-off on request
	initial begin : response_sink
		int stall_left;
		int calm_left;
		bit hold_taken;
		rsp.ready  = 1'b0;
		stall_left = 0;
		calm_left  = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 15) == 0)
					calm_left = $urandom_range(30, 100);
				else
					stall_left = gap_len();
			end
		end
	end

	// present one request beat on a falling edge and hold it until accepted
	task automatic offer(input logic mode, input logic [SIZE_W-1:0] size,
			input logic [ADDR_W-1:0] slot, input logic null_ptr);
		@(negedge clk);
		req.valid        <= 1'b1;
		req.mode         <= mode;
		req.request_size <= size;
		req.slot_address <= slot;
		req.no_address   <= null_ptr;
		do @(posedge clk); while (req.ready !== 1'b1);
		beats_sent++;
	endtask

	// drop valid between beats when n is nonzero; zero keeps the beats back to back
	task automatic idle_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			req.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic sender_gap();
		if (calm_items > 0) begin
			calm_items--;
		end else begin
			if ($urandom_range(0, 19) == 0)
				calm_items = $urandom_range(20, 60);
			idle_sender(gap_len());
		end
	endtask

	task automatic offer_paced(input logic mode, input logic [SIZE_W-1:0] size,
			input logic [ADDR_W-1:0] slot, input logic null_ptr);
		offer(mode, size, slot, null_ptr);
		sender_gap();
	endtask

	// stop sending and wait for every pending grant to come back
	task automatic drain();
		idle_sender(1);
		wait (outstanding == 0);
	endtask

	// reconfigure only while idle; extra falling-edge waits after the drain cover the slow pop path
	task automatic write_pool(input logic [PAGES_W-1:0] pages);
		drain();
		repeat (4) @(negedge clk);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= pages;
		@(negedge clk);
		cfg_we   <= 1'b0;
		live_slots.delete();
	endtask

	task automatic random_beat();
		int          r;
		int unsigned c;
		int unsigned k;
		slot_ref_t   s;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			r = $urandom_range(0, 9);
			c = (r < 3) ? CLS_SMALL : (r < 6) ? CLS_MEDIUM : (r < 9) ? CLS_LARGE : CLS_EXT;
			// address and null bits ride along on allocations and must be ignored
			offer_paced(MODE_ALLOC, size_in_class(c), ADDR_W'($urandom), 1'($urandom));
		end else if (r < 85 && live_slots.size() > 0) begin
			k = $urandom_range(0, live_slots.size() - 1);
			s = live_slots[k];
			live_slots.delete(k);
			offer_paced(MODE_FREE, size_in_class(s.cls), s.addr, 1'b0);
		end else begin
			case ($urandom_range(0, 3))
				0: offer_paced(MODE_FREE, size_in_class($urandom_range(0, 2)),
					ADDR_W'($urandom), 1'b1);
				1: offer_paced(MODE_FREE, size_in_class($urandom_range(0, 2)),
					ADDR_W'($urandom), 1'b0);
				2: offer_paced(1'($urandom), $urandom, ADDR_W'($urandom), 1'($urandom));
				default: offer_paced(1'($urandom), size_in_class(CLS_EXT),
					ADDR_W'($urandom), 1'($urandom));
			endcase
		end
	endtask

	initial begin : stimulus
		int unsigned pool_plan[5];
		int          p;
		int          n;
		req.valid        = 1'b0;
		req.mode         = MODE_ALLOC;
		req.request_size = '0;
		req.slot_address = '0;
		req.no_address   = 1'b0;
		@(posedge arst_n);
		repeat (2) @(negedge clk);

		// two pages: one goes to the small class, one to the medium, large starves
		write_pool(9'd2);
		offer_paced(MODE_ALLOC, 32'd0,   20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'd128, 20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'd129, 20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'd256, 20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'd257, 20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'd512, 20'h0, 1'b0);
		// external sizes, in both modes, and ahead of a null pointer
		offer_paced(MODE_ALLOC, 32'd513, 20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
		offer_paced(MODE_FREE,  32'hFFFF_FFFF, 20'h0, 1'b1);
		offer_paced(MODE_FREE,  32'd64, 20'h00080, 1'b1);
		// free then reallocate: the freed slot comes straight back
		offer_paced(MODE_FREE,  32'd128, 20'h00080, 1'b0);
		offer_paced(MODE_ALLOC, 32'd1,   20'h0, 1'b0);
		// unaligned and out-of-pool frees round down and come back masked
		offer_paced(MODE_FREE,  32'd200, 20'hFFFFF, 1'b0);
		offer_paced(MODE_ALLOC, 32'd255, 20'h0, 1'b0);
		offer_paced(MODE_FREE,  32'd1,   20'h12345, 1'b0);
		offer_paced(MODE_ALLOC, 32'd128, 20'h0, 1'b0);
		offer_paced(MODE_FREE,  32'd512, 20'h0, 1'b0);
		offer_paced(MODE_ALLOC, 32'd300, 20'h0, 1'b0);
		offer_paced(MODE_FREE,  32'd0,   20'h0, 1'b0);

		// empty pool: allocation fails at once, then stack a batch of large frees
		write_pool(9'd0);
		offer_paced(MODE_ALLOC, 32'd100, 20'h0, 1'b0);
		for (n = 0; n < FILL_FREES; n++)
			offer_paced(MODE_FREE, size_in_class(CLS_LARGE), ADDR_W'($urandom), 1'b0);
		for (n = 0; n < 3; n++)
			offer_paced(MODE_ALLOC, size_in_class(CLS_LARGE), 20'h0, 1'b0);
		offer_paced(MODE_FREE, 32'd512, 20'h00200, 1'b0);

		// random phases over full, saturated, single, mid-size and full pools
		pool_plan = '{MAX_PAGES, 9'h1FF, 1, $urandom_range(2, MAX_PAGES - 1), MAX_PAGES};
		for (p = 0; p < 5; p++) begin
			write_pool(PAGES_W'(pool_plan[p]));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// stall the response side for a long stretch while requests keep coming
				if (p == 0 && n == 20)
					hold_request = 1'b1;
				// pause the sender until every grant is back
				if (n == PHASE_ITEMS / 2)
					drain();
				random_beat();
			end
		end

		drain();
		repeat (10) @(negedge clk);
		$display("%0d request beats sent, %0d response beats checked, %0d mismatches",
			beats_sent, beats_checked, mismatches);
		$display("pool sizes 0, 1, 2, mid, 256 and an oversized write; statuses seen %b",
			status_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/scpa_pkg.sv
rtl/scpa_if.sv
rtl/scpa_ram.sv
rtl/scpa_ctrl.sv
rtl/scpa_dp.sv
rtl/size_class_pool_allocator_unit.sv
test/scpa_grant_checker.sv
test/tb_top.sv
